FILE: rtl/core/fbf_pkg.sv
// Package: widths and constants for the Fischer-Burmeister block.
`timescale 1ns / 1ps
`default_nettype none
package fbf_pkg;
  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int EpsWidth     = 16;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_FIRST_SIGN  = 2'd0,
    REG_SECOND_SIGN = 2'd1,
    REG_EPSILON     = 2'd2
  } cfg_reg_t;

  localparam logic OP_VALUE_ONLY = 1'b0;
  localparam logic OP_WITH_DERIV = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/fbf_if.sv
// Interfaces: valid/ready channels for input and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface fbf_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [DATA_WIDTH-1:0] first_value;
  logic signed [DATA_WIDTH-1:0] second_value;
  modport source (output valid, opcode, first_value, second_value, input ready);
  modport sink   (input valid, opcode, first_value, second_value, output ready);
endinterface

interface fbf_out_if #(parameter int DATA_WIDTH = 32, parameter int FRAC_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] fb_value;
  logic signed [FRAC_BITS+2:0]  deriv_first;
  logic signed [FRAC_BITS+2:0]  deriv_second;
  logic                         saturated;
  modport source (output valid, fb_value, deriv_first, deriv_second, saturated,
                  input ready);
  modport sink   (input valid, fb_value, deriv_first, deriv_second, saturated,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fischer_burmeister_function.sv
// Top level: pipelined Fischer-Burmeister value and partial derivatives.
// Stages: the input register loads at the accepting edge, then a squaring stage and a sum
// stage, DATA_WIDTH+1 root steps, FRAC_BITS+1 divide steps and 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances when the output
// register is free or being taken, so a stall freezes every stage.
`timescale 1ns / 1ps
`default_nettype none
module fischer_burmeister_function
  import fbf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0] cfg_data,
  fbf_in_if.sink                      in_ch,
  fbf_out_if.source                   out_ch
);
  // Reset: rst clears the valid bits and sets first_sign_le=0, second_sign_le=0, epsilon=1.
  localparam int SW = 2*DATA_WIDTH + 2;   // sum of squares (+eps) width
  localparam int QW = DATA_WIDTH + 1;     // root width
  localparam int NR = DATA_WIDTH + 1;     // root steps
  localparam int NQ = FRAC_BITS + 1;      // quotient bits
  localparam int DW = FRAC_BITS + 3;
  localparam int VW = DATA_WIDTH + 3;     // exact value width
  localparam int DEPTH = 2 + NR + NQ + 1; // stages before output register

  // configuration
  logic                first_sign_le, second_sign_le;
  logic [EpsWidth-1:0] epsilon;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sign_le  <= 1'b0;
      second_sign_le <= 1'b0;
      epsilon        <= EpsWidth'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SIGN:  first_sign_le  <= cfg_data[0];
        REG_SECOND_SIGN: second_sign_le <= cfg_data[0];
        REG_EPSILON:     epsilon        <= cfg_data[EpsWidth-1:0];
        default: ;
      endcase
    end
  end

  // global advance: stall everything when output holds an untaken result
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // per-stage side payload carried along the whole pipe
  typedef struct packed {
    logic                  op;
    logic                  an, bn;
    logic [DATA_WIDTH-1:0] am, bm;
    logic [VW-1:0]         lin;  // sa*a + sb*b, signed
  } side_t;

  logic  [DEPTH-1:0] vld;
  side_t             side [DEPTH];

  // stage 0: magnitudes and signed linear part
  logic [DATA_WIDTH-1:0] a_mag, b_mag;
  logic signed [VW-1:0]  a_ext, b_ext;
  always_comb begin
    a_ext = VW'(in_ch.first_value);
    b_ext = VW'(in_ch.second_value);
    a_mag = in_ch.first_value[DATA_WIDTH-1] ? DATA_WIDTH'(-a_ext) : in_ch.first_value;
    b_mag = in_ch.second_value[DATA_WIDTH-1] ? DATA_WIDTH'(-b_ext) : in_ch.second_value;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].op  <= in_ch.opcode;
      side[0].an  <= in_ch.first_value[DATA_WIDTH-1];
      side[0].bn  <= in_ch.second_value[DATA_WIDTH-1];
      side[0].am  <= a_mag;
      side[0].bm  <= b_mag;
      side[0].lin <= VW'((first_sign_le ? -a_ext : a_ext) +
                         (second_sign_le ? -b_ext : b_ext));
      for (int i = 1; i < DEPTH; i++) side[i] <= side[i-1];
    end
  end

  // stage 1: squares (registered multipliers)
  logic [2*DATA_WIDTH-1:0] asq, bsq;
  always_ff @(posedge clk) begin
    if (adv) begin
      asq <= side[0].am * side[0].am;
      bsq <= side[0].bm * side[0].bm;
    end
  end
  // stage 2: sum and sum+eps
  logic [SW-1:0] rem0 [NR+1];
  logic [SW-1:0] reme0 [NR+1];
  logic [QW-1:0] rt [NR+1];
  logic [QW-1:0] rte [NR+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      rem0[0]  <= SW'(asq) + SW'(bsq);
      reme0[0] <= SW'(asq) + SW'(bsq) + SW'(epsilon);
    end
  end
  assign rt[0]  = '0;
  assign rte[0] = '0;

  for (genvar k = 0; k < NR; k++) begin : g_root
    fbf_sqrt_stage #(.RW(SW), .QW(QW), .BIT(NR-1-k)) u_r (
      .clk(clk), .en(adv), .rem_in(rem0[k]), .root_in(rt[k]),
      .rem_out(rem0[k+1]), .root_out(rt[k+1]));
    fbf_sqrt_stage #(.RW(SW), .QW(QW), .BIT(NR-1-k)) u_re (
      .clk(clk), .en(adv), .rem_in(reme0[k]), .root_in(rte[k]),
      .rem_out(reme0[k+1]), .root_out(rte[k+1]));
  end

  // divide stages: long division of mag*2^FRAC_BITS by Re, one bit per stage
  localparam int RMW = QW + 1;
  logic [RMW-1:0] ra [NQ+1];
  logic [RMW-1:0] rb [NQ+1];
  logic [NQ-1:0]  qa [NQ+1];
  logic [NQ-1:0]  qb [NQ+1];
  logic [QW-1:0]  den [NQ+1];
  logic [QW-1:0]  rv  [NQ+1];
  localparam int S0 = 2 + NR; // index of side entry aligned with root output
  assign ra[0]  = RMW'(side[S0].am);
  assign rb[0]  = RMW'(side[S0].bm);
  assign qa[0]  = '0;
  assign qb[0]  = '0;
  assign den[0] = rte[NR];
  assign rv[0]  = rt[NR];

  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic [RMW-1:0] ta, tb;
    always_comb begin
      ta = (k == 0) ? ra[k] : (ra[k] << 1);
      tb = (k == 0) ? rb[k] : (rb[k] << 1);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        den[k+1] <= den[k];
        rv[k+1]  <= rv[k];
        if (ta >= RMW'(den[k])) begin
          ra[k+1] <= ta - RMW'(den[k]);
          qa[k+1] <= {qa[k][NQ-2:0], 1'b1};
        end else begin
          ra[k+1] <= ta;
          qa[k+1] <= {qa[k][NQ-2:0], 1'b0};
        end
        if (tb >= RMW'(den[k])) begin
          rb[k+1] <= tb - RMW'(den[k]);
          qb[k+1] <= {qb[k][NQ-2:0], 1'b1};
        end else begin
          rb[k+1] <= tb;
          qb[k+1] <= {qb[k][NQ-2:0], 1'b0};
        end
      end
    end
  end

  // final: value, saturation, derivatives (zero for value-only ops) into output register
  side_t                s_f;
  logic signed [VW-1:0] v;
  logic signed [VW-1:0] vmax, vmin;
  logic signed [DW-1:0] one_f, qas, qbs, sa_f, sb_f;
  logic [NQ-1:0]        qa_z, qb_z;
  always_comb begin
    s_f  = side[DEPTH-1];
    v    = $signed(s_f.lin) - $signed(VW'(rv[NQ]));
    vmax = VW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    vmin = -vmax - VW'(1);
    qa_z = (den[NQ] == '0) ? '0 : qa[NQ];
    qb_z = (den[NQ] == '0) ? '0 : qb[NQ];
    one_f = DW'(1) <<< FRAC_BITS;
    qas  = s_f.an ? -$signed(DW'(qa_z)) : $signed(DW'(qa_z));
    qbs  = s_f.bn ? -$signed(DW'(qb_z)) : $signed(DW'(qb_z));
    sa_f = first_sign_le ? -one_f : one_f;
    sb_f = second_sign_le ? -one_f : one_f;
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= vld[DEPTH-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v > vmax) begin
        out_ch.fb_value <= vmax[DATA_WIDTH-1:0];
        out_ch.saturated <= 1'b1;
      end else if (v < vmin) begin
        out_ch.fb_value <= vmin[DATA_WIDTH-1:0];
        out_ch.saturated <= 1'b1;
      end else begin
        out_ch.fb_value <= v[DATA_WIDTH-1:0];
        out_ch.saturated <= 1'b0;
      end
      out_ch.deriv_first  <= (s_f.op == OP_WITH_DERIV) ? sa_f - qas : '0;
      out_ch.deriv_second <= (s_f.op == OP_WITH_DERIV) ? sb_f - qbs : '0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/fbf_sqrt_stage.sv
// One restoring square-root step (one root bit) for one radicand, registered.
`timescale 1ns / 1ps
`default_nettype none
module fbf_sqrt_stage #(
  parameter int RW = 66,
  parameter int QW = 33,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [QW-1:0] root_in,
  output logic      [RW-1:0] rem_out,
  output logic      [QW-1:0] root_out
);
  // restoring form: trial = (2*root + 2^BIT) << BIT, compared against the remainder
  logic [RW+1:0] trial;
  logic [RW+1:0] rem_ext;
  always_comb begin
    trial   = ({{(RW+2-QW){1'b0}}, root_in} << (BIT+1)) | ((RW+2)'(1) << (2*BIT));
    rem_ext = {2'b00, rem_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (trial <= rem_ext) begin
        rem_out  <= RW'(rem_ext - trial);
        root_out <= root_in | (QW'(1) << BIT);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/fbf_checker.sv
// Checker: port-level properties of the Fischer-Burmeister block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module fbf_checker
  import fbf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] fb_value,
  input wire logic                  saturated
);
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with free output");
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fb_value))
    else $error("result dropped under stall");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (fb_value == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
                                fb_value == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
    else $error("saturation flag without clipped value");
endmodule

bind fischer_burmeister_function fbf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_fbf_checker (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .fb_value(out_ch.fb_value),
  .saturated(out_ch.saturated));
`default_nettype wire
